// ----- design/slabdw_pkg.sv -----
// Shared types, constants and saturation helpers for the slab dipole / wall /
// spring force block. No dependencies.
package slabdw_pkg;

   localparam int NumAtoms   = 64;
   localparam int NumCharges = 64;
   localparam int AtomBits   = 6;
   localparam int CountBits  = 7;

   localparam logic [1:0] TYPE_CHARGE = 2'd0;
   localparam logic [1:0] TYPE_WALL   = 2'd1;
   localparam logic [1:0] TYPE_SPRING = 2'd2;
   localparam logic [1:0] TYPE_FINISH = 2'd3;

   localparam logic [2:0] CSR_AXIS   = 3'd0;
   localparam logic [2:0] CSR_COEF   = 3'd1;
   localparam logic [2:0] CSR_WLOW   = 3'd2;
   localparam logic [2:0] CSR_WHIGH  = 3'd3;
   localparam logic [2:0] CSR_WSTIFF = 3'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [5:0]         atom_index;
      logic signed [31:0] charge_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] anchor_x;
      logic signed [31:0] anchor_y;
      logic signed [31:0] anchor_z;
      logic [30:0]        spring_constant;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]         out_atom;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [47:0] total_energy;
      logic               status_code;
      logic               last_result;
   } rsp_payload_type;

   // request to the shared multiplier: (a*b) >> (half ? 17 : 16), saturated
   typedef struct packed {
      logic               start;
      logic               half;
      logic signed [47:0] a;
      logic signed [47:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [47:0] value;
   } mul_rsp_type;

   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      logic signed [47:0] r;
      if (v > 49'sh0_7FFF_FFFF_FFFF)
         r = 48'sh7FFF_FFFF_FFFF;
      else if (v < -49'sh0_8000_0000_0000)
         r = 48'sh8000_0000_0000;
      else
         r = v[47:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > 49'sh0_0000_7FFF_FFFF)
         r = 32'sh7FFF_FFFF;
      else if (v < -49'sh0_0000_8000_0000)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

// ----- design/slabdw_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on slabdw_pkg.
interface slabdw_req_if;
   import slabdw_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface slabdw_rsp_if;
   import slabdw_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- design/slab_dipole_wall_spring_forces.sv -----
// Top level of the slab dipole / wall / spring force accumulator.
// Depends on slabdw_pkg, slabdw_if and slabdw_mul.
//
// Usage: items arrive on req_ch (valid/ready), results leave on rsp_ch from
// an output register. Registers are written through csr_we/csr_index/
// csr_wdata; the user must write them only while the block is idle, as the
// block itself does not enforce it; indexes beyond the list are dropped.
// One item is taken at a time; req_ch.ready is high only while idle.
// Every product goes through one shared multiplier. A finish item first
// works through each stored charge, then the energy term, then walks over
// atoms 1..63 and emits one result per touched atom, or emits one result
// when no atom was touched or an error was seen. Force stores are
// memories; an entry is zeroed when its atom is first touched, so clearing
// the step only drops flags and counters.
// Reset: registers to their defaults, step state empty, no result pending.
// A stalled receiver holds the current result; the walk waits on it, and the
// next item is accepted once the finish item's last result is loaded.
module slab_dipole_wall_spring_forces
   import slabdw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   slabdw_req_if.sink  req_ch,
   slabdw_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHECK    = 4'd1;
   localparam logic [3:0] S_CH_MUL   = 4'd2;
   localparam logic [3:0] S_F_MUL    = 4'd3;
   localparam logic [3:0] S_E_MUL    = 4'd4;
   localparam logic [3:0] S_FIN_LOOP = 4'd5;
   localparam logic [3:0] S_FIN_GO   = 4'd6;
   localparam logic [3:0] S_FIN_P    = 4'd7;
   localparam logic [3:0] S_FIN_G    = 4'd8;
   localparam logic [3:0] S_FIN_T    = 4'd9;
   localparam logic [3:0] S_FIN_E    = 4'd10;
   localparam logic [3:0] S_SCAN     = 4'd11;
   localparam logic [3:0] S_SCAN_RD  = 4'd12;
   localparam logic [3:0] S_SCAN_OUT = 4'd13;
   localparam logic [3:0] S_ONE      = 4'd14;

   // configuration
   logic [1:0]         axis_ff;
   logic signed [31:0] coef_ff, wlow_ff, whigh_ff;
   logic [30:0]        wstiff_ff;

   // step state
   logic [NumAtoms-1:0]  touched_ff;
   logic [CountBits-1:0] count_ff;
   logic signed [47:0]   dipole_ff, energy_ff;
   logic                 error_ff;

   // item registers
   logic [3:0]         state_ff, state_in;
   req_payload_type    item_ff;
   logic [1:0]         cur_axis_ff, cur_axis_in;
   logic signed [47:0] d_ff, d_in;
   logic signed [47:0] f_ff, f_in;
   logic [CountBits-1:0] idx_ff, idx_in;

   // memories
   logic [31:0] fmem_x[NumAtoms];
   logic [31:0] fmem_y[NumAtoms];
   logic [31:0] fmem_z[NumAtoms];
   logic [AtomBits-1:0] cmem_atom[NumCharges];
   logic [31:0]         cmem_q[NumCharges];
   logic signed [31:0]  frd_ff[3];
   logic [AtomBits-1:0] catom_rd_ff;
   logic signed [31:0]  cq_rd_ff;

   logic [2:0]          fw_en;
   logic [AtomBits-1:0] fw_addr, fr_addr;
   logic signed [31:0]  fw_data;
   logic                cw_en;

   mul_req_type mrq;
   mul_rsp_type mrs;

   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff;
   logic            rsp_load;
   logic            out_free;

   // step-state update requests
   logic touch_set, error_set, clear_step, dipole_upd, energy_upd, count_inc;
   logic signed [47:0] dipole_in, energy_in;

   logic [1:0]         ax;
   logic signed [31:0] pos[3];
   logic signed [31:0] anc[3];
   logic signed [47:0] wall_d;
   logic [NumAtoms-1:0] above;
   logic                bad_atom;

   slabdw_mul u_mul (
      .clock (clock),
      .reset (reset),
      .rq    (mrq),
      .rs    (mrs)
   );

   assign ax       = (axis_ff == 2'd3) ? 2'd2 : axis_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign bad_atom = (item_ff.atom_index == '0);

   always_comb begin
      pos[0] = item_ff.pos_x;
      pos[1] = item_ff.pos_y;
      pos[2] = item_ff.pos_z;
      anc[0] = item_ff.anchor_x;
      anc[1] = item_ff.anchor_y;
      anc[2] = item_ff.anchor_z;
      if (pos[ax] < wlow_ff)
         wall_d = 48'(pos[ax]) - 48'(wlow_ff);
      else if (pos[ax] > whigh_ff)
         wall_d = 48'(pos[ax]) - 48'(whigh_ff);
      else
         wall_d = '0;
      above = touched_ff >> idx_ff[AtomBits-1:0];
   end

   always_comb begin
      state_in    = state_ff;
      cur_axis_in = cur_axis_ff;
      d_in        = d_ff;
      f_in        = f_ff;
      idx_in      = idx_ff;
      mrq         = '0;
      fw_en       = '0;
      fw_addr     = item_ff.atom_index;
      fw_data     = '0;
      fr_addr     = item_ff.atom_index;
      cw_en       = 1'b0;
      rsp_load    = 1'b0;
      rsp_in      = '0;
      touch_set   = 1'b0;
      error_set   = 1'b0;
      clear_step  = 1'b0;
      dipole_upd  = 1'b0;
      energy_upd  = 1'b0;
      count_inc   = 1'b0;
      dipole_in   = sat48(49'(dipole_ff) + 49'(mrs.value));
      energy_in   = sat48(49'(energy_ff) + 49'(mrs.value));

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid)
               state_in = S_CHECK;
         end
         S_CHECK: begin
            if (item_ff.req_type == TYPE_FINISH) begin
               idx_in   = '0;
               state_in = error_ff ? S_ONE : S_FIN_LOOP;
            end else if (bad_atom) begin
               error_set = 1'b1;
               state_in  = S_IDLE;
            end else begin
               touch_set = 1'b1;
               if (!touched_ff[item_ff.atom_index])
                  fw_en = 3'b111;   // first touch: zero the entry
               mrq.start = 1'b1;
               case (item_ff.req_type)
                  TYPE_CHARGE: begin
                     mrq.a    = 48'(item_ff.charge_value);
                     mrq.b    = 48'(pos[ax]);
                     state_in = S_CH_MUL;
                  end
                  TYPE_WALL: begin
                     mrq.a       = 48'({1'b0, wstiff_ff});
                     mrq.b       = wall_d;
                     d_in        = wall_d;
                     cur_axis_in = ax;
                     state_in    = S_F_MUL;
                  end
                  default: begin
                     mrq.a       = 48'({1'b0, item_ff.spring_constant});
                     mrq.b       = 48'(pos[0]) - 48'(anc[0]);
                     d_in        = 48'(pos[0]) - 48'(anc[0]);
                     cur_axis_in = 2'd0;
                     state_in    = S_F_MUL;
                  end
               endcase
            end
         end
         S_CH_MUL: begin
            if (mrs.done) begin
               dipole_upd = 1'b1;
               if (count_ff < CountBits'(NumCharges)) begin
                  cw_en     = 1'b1;
                  count_inc = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_F_MUL: begin
            if (mrs.done) begin
               f_in      = mrs.value;
               mrq.start = 1'b1;
               mrq.half  = 1'b1;
               mrq.a     = mrs.value;
               mrq.b     = d_ff;
               state_in  = S_E_MUL;
            end
         end
         S_E_MUL: begin
            if (mrs.done) begin
               energy_upd = 1'b1;
               fw_en[cur_axis_ff] = 1'b1;
               fw_data = sat32(49'(frd_ff[cur_axis_ff]) - 49'(f_ff));
               if (item_ff.req_type == TYPE_WALL || cur_axis_ff == 2'd2) begin
                  state_in = S_IDLE;
               end else begin
                  cur_axis_in = cur_axis_ff + 2'd1;
                  d_in = 48'(pos[cur_axis_ff + 2'd1]) - 48'(anc[cur_axis_ff + 2'd1]);
                  mrq.start = 1'b1;
                  mrq.a     = 48'({1'b0, item_ff.spring_constant});
                  mrq.b     = d_in;
                  state_in  = S_F_MUL;
               end
            end
         end
         S_FIN_LOOP: begin
            fr_addr = catom_rd_ff;
            if (idx_ff < count_ff) begin
               state_in = S_FIN_GO;
            end else begin
               mrq.start = 1'b1;
               mrq.a     = dipole_ff;
               mrq.b     = dipole_ff;
               state_in  = S_FIN_T;
            end
         end
         S_FIN_GO: begin
            fr_addr   = catom_rd_ff;
            mrq.start = 1'b1;
            mrq.a     = 48'(cq_rd_ff);
            mrq.b     = 48'(coef_ff);
            state_in  = S_FIN_P;
         end
         S_FIN_P: begin
            fr_addr = catom_rd_ff;
            if (mrs.done) begin
               mrq.start = 1'b1;
               mrq.a     = sat48({mrs.value, 1'b0});
               mrq.b     = dipole_ff;
               state_in  = S_FIN_G;
            end
         end
         S_FIN_G: begin
            fr_addr = catom_rd_ff;
            if (mrs.done) begin
               fw_en[ax] = 1'b1;
               fw_addr   = catom_rd_ff;
               fw_data   = sat32(49'(frd_ff[ax]) - 49'(mrs.value));
               idx_in    = idx_ff + 1'b1;
               state_in  = S_FIN_LOOP;
            end
         end
         S_FIN_T: begin
            if (mrs.done) begin
               mrq.start = 1'b1;
               mrq.a     = 48'(coef_ff);
               mrq.b     = mrs.value;
               state_in  = S_FIN_E;
            end
         end
         S_FIN_E: begin
            if (mrs.done) begin
               energy_upd = 1'b1;
               idx_in     = CountBits'(1);
               state_in   = (touched_ff == '0) ? S_ONE : S_SCAN;
            end
         end
         S_SCAN: begin
            fr_addr = idx_ff[AtomBits-1:0];
            if (touched_ff[idx_ff[AtomBits-1:0]])
               state_in = S_SCAN_RD;
            else
               idx_in = idx_ff + 1'b1;
         end
         S_SCAN_RD: begin
            fr_addr  = idx_ff[AtomBits-1:0];
            state_in = S_SCAN_OUT;
         end
         S_SCAN_OUT: begin
            fr_addr = idx_ff[AtomBits-1:0];
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_in.out_atom     = idx_ff[AtomBits-1:0];
               rsp_in.force_x      = frd_ff[0];
               rsp_in.force_y      = frd_ff[1];
               rsp_in.force_z      = frd_ff[2];
               rsp_in.total_energy = energy_ff;
               rsp_in.last_result  = (above[NumAtoms-1:1] == '0);
               if (above[NumAtoms-1:1] == '0) begin
                  clear_step = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_ONE: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_in.total_energy = error_ff ? '0 : energy_ff;
               rsp_in.status_code  = error_ff;
               rsp_in.last_result  = 1'b1;
               clear_step          = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff   <= 2'd2;
         coef_ff   <= '0;
         wlow_ff   <= '0;
         whigh_ff  <= '0;
         wstiff_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AXIS:   axis_ff   <= csr_wdata[1:0];
            CSR_COEF:   coef_ff   <= csr_wdata;
            CSR_WLOW:   wlow_ff   <= csr_wdata;
            CSR_WHIGH:  whigh_ff  <= csr_wdata;
            CSR_WSTIFF: wstiff_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // control and step state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         touched_ff   <= '0;
         count_ff     <= '0;
         dipole_ff    <= '0;
         energy_ff    <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cur_axis_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         cur_axis_ff <= cur_axis_in;
         if (touch_set)
            touched_ff[item_ff.atom_index] <= 1'b1;
         if (error_set)
            error_ff <= 1'b1;
         if (dipole_upd)
            dipole_ff <= dipole_in;
         if (energy_upd)
            energy_ff <= energy_in;
         if (count_inc)
            count_ff <= count_ff + 1'b1;
         if (clear_step) begin
            touched_ff <= '0;
            count_ff   <= '0;
            dipole_ff  <= '0;
            energy_ff  <= '0;
            error_ff   <= 1'b0;
         end
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_ch.valid)
         item_ff <= req_ch.data;
      d_ff <= d_in;
      f_ff <= f_in;
      if (rsp_load)
         rsp_ff <= rsp_in;
   end

   // force stores
   always_ff @(posedge clock) begin
      if (fw_en[0])
         fmem_x[fw_addr] <= fw_data;
      if (fw_en[1])
         fmem_y[fw_addr] <= fw_data;
      if (fw_en[2])
         fmem_z[fw_addr] <= fw_data;
      frd_ff[0] <= fmem_x[fr_addr];
      frd_ff[1] <= fmem_y[fr_addr];
      frd_ff[2] <= fmem_z[fr_addr];
   end

   // charge list
   always_ff @(posedge clock) begin
      if (cw_en) begin
         cmem_atom[count_ff[AtomBits-1:0]] <= item_ff.atom_index;
         cmem_q[count_ff[AtomBits-1:0]]    <= item_ff.charge_value;
      end
      catom_rd_ff <= cmem_atom[idx_ff[AtomBits-1:0]];
      cq_rd_ff    <= cmem_q[idx_ff[AtomBits-1:0]];
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

endmodule

// ----- design/slabdw_mul.sv -----
// Shared multiplier: 48x48 magnitude product built from three 48x16 partials,
// then shift by 16 or 17, truncate toward zero, saturate to 48 bits.
// Depends on slabdw_pkg.
module slabdw_mul
   import slabdw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type rq,
   output mul_rsp_type rs
);

   logic [47:0]        ma_ff, mb_ff;
   logic               neg_ff, half_ff, busy_ff, done_ff;
   logic [1:0]         step_ff;
   logic [95:0]        acc_ff;
   logic signed [47:0] value_ff;

   logic [15:0] digit;
   logic [63:0] partial;
   logic [95:0] placed;
   logic [95:0] shifted;
   logic [95:0] cap;
   logic [95:0] mag;

   always_comb begin
      case (step_ff)
         2'd0:    digit = mb_ff[15:0];
         2'd1:    digit = mb_ff[31:16];
         default: digit = mb_ff[47:32];
      endcase
      partial = 64'(ma_ff) * 64'(digit);
      case (step_ff)
         2'd0:    placed = 96'(partial);
         2'd1:    placed = 96'(partial) << 16;
         default: placed = 96'(partial) << 32;
      endcase
      shifted = half_ff ? (acc_ff >> 17) : (acc_ff >> 16);
      cap     = 96'(48'h7FFF_FFFF_FFFF) + 96'(neg_ff);
      mag     = (shifted > cap) ? cap : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (rq.start) begin
            ma_ff   <= rq.a[47] ? 48'(-rq.a) : 48'(rq.a);
            mb_ff   <= rq.b[47] ? 48'(-rq.b) : 48'(rq.b);
            neg_ff  <= rq.a[47] ^ rq.b[47];
            half_ff <= rq.half;
            acc_ff  <= '0;
            step_ff <= 2'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (step_ff != 2'd3) begin
               acc_ff  <= acc_ff + placed;
               step_ff <= step_ff + 2'd1;
            end else begin
               value_ff <= neg_ff ? -$signed(mag[47:0]) : $signed(mag[47:0]);
               done_ff  <= 1'b1;
               busy_ff  <= 1'b0;
            end
         end
      end
   end

   assign rs.done  = done_ff;
   assign rs.value = value_ff;

endmodule
